[hdl/assert_macros.svh]
// assertion macros for the decimal multiplier rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ddm assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ddm forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

[hdl/ddm_pkg.sv]
// shared types and constants of the decimal digit multiplier
// no dependencies; imported by every ddm module
package ddm_pkg;

    // port word width and digit geometry
    localparam int WORD_W         = 32;
    localparam int NIBBLE_W       = 4;
    localparam int MAX_DIGITS     = 8;
    localparam int DIGITS_DEFAULT = 8;

    // decimal radix and largest legal digit
    localparam int RADIX     = 10;
    localparam int DIGIT_MAX = 9;

    // digit product (max 81) and column sum (max 8 * 81 = 648)
    localparam int PROD_W = 7;
    localparam int COL_W  = 10;

    // column digits after the first split (max 24) and second split (max 10)
    localparam int SPLIT_W = 5;
    localparam int NORM_W  = 4;

    // control that travels with each word through the stages
    typedef struct packed {
        logic valid;
        logic bad;
    } ddm_ctl_t;

endpackage

[hdl/decimal_digit_multiplier.sv]
// top level of the pipelined packed-bcd multiplier
// depends on ddm_pkg, assert_macros.svh and the four ddm stage modules
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_stall   | multiplicand_bcd, multiplier_bcd
//  out     | output    | out_valid / out_stall | product_high_bcd, product_low_bcd,
//          |           |                       | invalid_digit
//
// five register stages: digit products, column sums, digit split, carry-save
// pass, carry prefix with the output register.
// one word enters and one leaves per cycle while out_stall stays low.
// reset clears only the valid bits; payload registers are not reset.
// out_stall holds full stages; empty stages keep filling, and in_stall rises
// only when every stage holds a word and the output is stalled.
`include "assert_macros.svh"

module decimal_digit_multiplier #(
    parameter int DIGITS = ddm_pkg::DIGITS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [ddm_pkg::WORD_W-1:0] multiplicand_bcd,
    input  logic [ddm_pkg::WORD_W-1:0] multiplier_bcd,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [ddm_pkg::WORD_W-1:0] product_high_bcd,
    output logic [ddm_pkg::WORD_W-1:0] product_low_bcd,
    output logic                       invalid_digit
);
    import ddm_pkg::*;

    localparam logic [WORD_W-1:0] USED_MASK = (DIGITS >= MAX_DIGITS) ? '1 :
        WORD_W'((64'd1 << (NIBBLE_W * DIGITS)) - 64'd1);

    ddm_ctl_t          ctl1;
    ddm_ctl_t          ctl2;
    ddm_ctl_t          ctl4;
    logic              ready1;
    logic              ready2;
    logic              ready3;
    logic              ready5;
    logic [PROD_W-1:0] prod [DIGITS][DIGITS];
    logic [COL_W-1:0]  col  [2*DIGITS-1];
    logic [NORM_W-1:0] norm [2*DIGITS];

    // stage 1: digit products
    ddm_digit_products #(
        .DIGITS(DIGITS)
    ) u_products (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .multiplicand_bcd (multiplicand_bcd),
        .multiplier_bcd   (multiplier_bcd),
        .ready_out        (ready2),
        .ready_in         (ready1),
        .ctl_out          (ctl1),
        .prod             (prod)
    );

    // stage 2: column sums
    ddm_column_sum #(
        .DIGITS(DIGITS)
    ) u_columns (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (ctl1),
        .prod      (prod),
        .ready_out (ready3),
        .ready_in  (ready2),
        .ctl_out   (ctl2),
        .col       (col)
    );

    // stages 3 and 4: digit split and carry-save passes
    ddm_digit_normalize #(
        .DIGITS(DIGITS)
    ) u_normalize (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (ctl2),
        .col       (col),
        .ready_out (ready5),
        .ready_in  (ready3),
        .ctl_out   (ctl4),
        .norm      (norm)
    );

    // stage 5: carry resolve and output word
    ddm_carry_resolve #(
        .DIGITS(DIGITS)
    ) u_resolve (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl_in           (ctl4),
        .norm             (norm),
        .out_stall        (out_stall),
        .ready_in         (ready5),
        .out_valid        (out_valid),
        .product_high_bcd (product_high_bcd),
        .product_low_bcd  (product_low_bcd),
        .invalid_digit    (invalid_digit)
    );

    assign in_stall = !ready1;

    // a bad operand word always leaves as an all-zero product
    `ASSERT_PROP(a_bad_gives_zero, clk, rst_n, out_valid && invalid_digit |-> product_high_bcd == '0 && product_low_bcd == '0)

    // digits above the configured width stay clear
    `ASSERT_PROP(a_unused_digits_clear, clk, rst_n, out_valid |-> (product_high_bcd & ~USED_MASK) == '0 && (product_low_bcd & ~USED_MASK) == '0)

    // input is held back only when the whole pipe is full and stalled
    `ASSERT_PROP(a_stall_only_when_full, clk, rst_n, in_stall |-> ctl1.valid && ctl2.valid && ctl4.valid && out_valid && out_stall)

    // a stalled full output stage must not take a new word
    `ASSERT_NEVER(a_no_overwrite, clk, rst_n, out_valid && out_stall && ready5)

endmodule

[hdl/ddm_digit_products.sv]
// stage 1: digit check and all digit-by-digit products
// depends on ddm_pkg
module ddm_digit_products #(
    parameter int DIGITS = ddm_pkg::DIGITS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [ddm_pkg::WORD_W-1:0] multiplicand_bcd,
    input  logic [ddm_pkg::WORD_W-1:0] multiplier_bcd,
    input  logic                      ready_out,
    output logic                      ready_in,
    output ddm_pkg::ddm_ctl_t         ctl_out,
    output logic [ddm_pkg::PROD_W-1:0] prod [DIGITS][DIGITS]
);
    import ddm_pkg::*;

    logic                valid_reg;
    logic                bad_reg;
    logic                bad_next;
    logic [PROD_W-1:0]   prod_reg  [DIGITS][DIGITS];
    logic [PROD_W-1:0]   prod_next [DIGITS][DIGITS];
    logic [NIBBLE_W-1:0] a_dig [DIGITS];
    logic [NIBBLE_W-1:0] b_dig [DIGITS];

    // stage takes a word when empty or when its word moves on
    assign ready_in = !valid_reg || ready_out;

    // unpack the used digits and flag any nibble above nine
    always_comb
    begin
        bad_next = 1'b0;
        for (int i = 0; i < DIGITS; i++)
        begin
            a_dig[i] = multiplicand_bcd[i*NIBBLE_W +: NIBBLE_W];
            b_dig[i] = multiplier_bcd[i*NIBBLE_W +: NIBBLE_W];
            if (a_dig[i] > NIBBLE_W'(DIGIT_MAX) || b_dig[i] > NIBBLE_W'(DIGIT_MAX))
            begin
                bad_next = 1'b1;
            end
        end
    end

    // 4x4 digit products, forced to zero for a bad word
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            for (int j = 0; j < DIGITS; j++)
            begin
                if (bad_next)
                begin
                    prod_next[i][j] = '0;
                end
                else
                begin
                    prod_next[i][j] = PROD_W'({3'b000, a_dig[i]} * {3'b000, b_dig[j]});
                end
            end
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_in)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ready_in && in_valid)
        begin
            bad_reg  <= bad_next;
            prod_reg <= prod_next;
        end
    end

    assign ctl_out = '{valid: valid_reg, bad: bad_reg};
    assign prod    = prod_reg;

endmodule

[hdl/ddm_column_sum.sv]
// stage 2: sums digit products of equal weight into decimal columns
// depends on ddm_pkg
module ddm_column_sum #(
    parameter int DIGITS = ddm_pkg::DIGITS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ddm_pkg::ddm_ctl_t          ctl_in,
    input  logic [ddm_pkg::PROD_W-1:0] prod [DIGITS][DIGITS],
    input  logic                       ready_out,
    output logic                       ready_in,
    output ddm_pkg::ddm_ctl_t          ctl_out,
    output logic [ddm_pkg::COL_W-1:0]  col [2*DIGITS-1]
);
    import ddm_pkg::*;

    localparam int COLS = 2 * DIGITS - 1;

    logic             valid_reg;
    logic             bad_reg;
    logic [COL_W-1:0] col_reg  [COLS];
    logic [COL_W-1:0] col_next [COLS];

    assign ready_in = !valid_reg || ready_out;

    // column k gathers every product a[i] * b[k-i]
    always_comb
    begin
        for (int k = 0; k < COLS; k++)
        begin
            col_next[k] = '0;
            for (int i = 0; i < DIGITS; i++)
            begin
                if (k - i >= 0 && k - i < DIGITS)
                begin
                    col_next[k] = col_next[k] + COL_W'(prod[i][k-i]);
                end
            end
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_in)
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ready_in && ctl_in.valid)
        begin
            bad_reg <= ctl_in.bad;
            col_reg <= col_next;
        end
    end

    assign ctl_out = '{valid: valid_reg, bad: bad_reg};
    assign col     = col_reg;

endmodule

[hdl/ddm_digit_normalize.sv]
// stages 3 and 4: splits column sums into digits and shifts the
// tens upward until every column holds at most ten
// depends on ddm_pkg
module ddm_digit_normalize #(
    parameter int DIGITS = ddm_pkg::DIGITS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ddm_pkg::ddm_ctl_t          ctl_in,
    input  logic [ddm_pkg::COL_W-1:0]  col [2*DIGITS-1],
    input  logic                       ready_out,
    output logic                       ready_in,
    output ddm_pkg::ddm_ctl_t          ctl_out,
    output logic [ddm_pkg::NORM_W-1:0] norm [2*DIGITS]
);
    import ddm_pkg::*;

    localparam int COLS_IN  = 2 * DIGITS - 1;
    localparam int COLS     = 2 * DIGITS;
    localparam int QUOT_W   = 7;
    localparam int MUL_W    = COL_W + 8;
    localparam int RECIP    = 205;
    localparam int RECIP_SH = 11;

    // x / 10 for x below 1029 as (x * 205) >> 11
    function automatic logic [QUOT_W-1:0] div_ten(input logic [COL_W-1:0] x);
        logic [MUL_W-1:0] m;
        m = MUL_W'(x) * MUL_W'(RECIP);
        return QUOT_W'(m >> RECIP_SH);
    endfunction

    logic                valid3_reg;
    logic                bad3_reg;
    logic                valid4_reg;
    logic                bad4_reg;
    logic                ready3;
    logic                ready4;
    logic [SPLIT_W-1:0]  split_reg  [COLS];
    logic [SPLIT_W-1:0]  split_next [COLS];
    logic [NORM_W-1:0]   norm_reg   [COLS];
    logic [NORM_W-1:0]   norm_next  [COLS];
    logic [NIBBLE_W-1:0] d0 [COLS_IN];
    logic [NIBBLE_W-1:0] d1 [COLS_IN];
    logic [2:0]          d2 [COLS_IN];

    assign ready4   = !valid4_reg || ready_out;
    assign ready3   = !valid3_reg || ready4;
    assign ready_in = ready3;

    // each column sum (at most 648) as hundreds, tens and units
    always_comb
    begin
        logic [QUOT_W-1:0] q1;
        logic [QUOT_W-1:0] q2;
        for (int k = 0; k < COLS_IN; k++)
        begin
            q1    = div_ten(col[k]);
            q2    = div_ten(COL_W'(q1));
            d0[k] = NIBBLE_W'(col[k] - COL_W'(q1) * COL_W'(RADIX));
            d1[k] = NIBBLE_W'(q1 - q2 * QUOT_W'(RADIX));
            d2[k] = q2[2:0];
        end
    end

    // realign digits by weight: each column now at most 24
    always_comb
    begin
        for (int k = 0; k < COLS; k++)
        begin
            split_next[k] = '0;
            if (k < COLS_IN)
            begin
                split_next[k] = split_next[k] + SPLIT_W'(d0[k]);
            end
            if (k >= 1 && k - 1 < COLS_IN)
            begin
                split_next[k] = split_next[k] + SPLIT_W'(d1[k-1]);
            end
            if (k >= 2)
            begin
                split_next[k] = split_next[k] + SPLIT_W'(d2[k-2]);
            end
        end
    end

    // two small carry-save passes bring each column to at most ten
    always_comb
    begin
        logic [1:0]          e1 [COLS];
        logic [NIBBLE_W-1:0] e0 [COLS];
        logic [NIBBLE_W-1:0] w  [COLS];
        logic                f1 [COLS];
        logic [NIBBLE_W-1:0] f0 [COLS];
        for (int k = 0; k < COLS; k++)
        begin
            if (split_reg[k] >= SPLIT_W'(2 * RADIX))
            begin
                e1[k] = 2'd2;
            end
            else if (split_reg[k] >= SPLIT_W'(RADIX))
            begin
                e1[k] = 2'd1;
            end
            else
            begin
                e1[k] = 2'd0;
            end
            e0[k] = NIBBLE_W'(split_reg[k] - SPLIT_W'(e1[k]) * SPLIT_W'(RADIX));
        end
        for (int k = 0; k < COLS; k++)
        begin
            w[k]  = (k == 0) ? e0[k] : e0[k] + NIBBLE_W'(e1[k-1]);
            f1[k] = (w[k] >= NIBBLE_W'(RADIX));
            f0[k] = f1[k] ? w[k] - NIBBLE_W'(RADIX) : w[k];
        end
        for (int k = 0; k < COLS; k++)
        begin
            norm_next[k] = (k == 0) ? f0[k] : f0[k] + NIBBLE_W'(f1[k-1]);
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
        end
        else
        begin
            if (ready3)
            begin
                valid3_reg <= ctl_in.valid;
            end
            if (ready4)
            begin
                valid4_reg <= valid3_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ready3 && ctl_in.valid)
        begin
            bad3_reg  <= ctl_in.bad;
            split_reg <= split_next;
        end
        if (ready4 && valid3_reg)
        begin
            bad4_reg <= bad3_reg;
            norm_reg <= norm_next;
        end
    end

    assign ctl_out = '{valid: valid4_reg, bad: bad4_reg};
    assign norm    = norm_reg;

endmodule

[hdl/ddm_carry_resolve.sv]
// stage 5: resolves the last single carries with a prefix network
// and holds the output word
// depends on ddm_pkg
module ddm_carry_resolve #(
    parameter int DIGITS = ddm_pkg::DIGITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ddm_pkg::ddm_ctl_t           ctl_in,
    input  logic [ddm_pkg::NORM_W-1:0]  norm [2*DIGITS],
    input  logic                        out_stall,
    output logic                        ready_in,
    output logic                        out_valid,
    output logic [ddm_pkg::WORD_W-1:0]  product_high_bcd,
    output logic [ddm_pkg::WORD_W-1:0]  product_low_bcd,
    output logic                        invalid_digit
);
    import ddm_pkg::*;

    localparam int COLS   = 2 * DIGITS;
    localparam int LEVELS = $clog2(COLS);

    logic              valid_reg;
    logic              bad_reg;
    logic [WORD_W-1:0] high_reg;
    logic [WORD_W-1:0] high_next;
    logic [WORD_W-1:0] low_reg;
    logic [WORD_W-1:0] low_next;
    logic [COLS-1:0]   carry_in;

    assign ready_in = !valid_reg || !out_stall;

    // column of ten generates a carry, column of nine passes one on
    always_comb
    begin
        logic [COLS-1:0] g_cur;
        logic [COLS-1:0] p_cur;
        logic [COLS-1:0] g_nxt;
        logic [COLS-1:0] p_nxt;
        for (int k = 0; k < COLS; k++)
        begin
            g_cur[k] = (norm[k] == NORM_W'(RADIX));
            p_cur[k] = (norm[k] == NORM_W'(DIGIT_MAX));
        end
        for (int lvl = 0; lvl < LEVELS; lvl++)
        begin
            g_nxt = g_cur;
            p_nxt = p_cur;
            for (int k = 0; k < COLS; k++)
            begin
                if (k >= (1 << lvl))
                begin
                    g_nxt[k] = g_cur[k] | (p_cur[k] & g_cur[k - (1 << lvl)]);
                    p_nxt[k] = p_cur[k] & p_cur[k - (1 << lvl)];
                end
            end
            g_cur = g_nxt;
            p_cur = p_nxt;
        end
        carry_in = {g_cur[COLS-2:0], 1'b0};
    end

    // final digits packed into the two halves
    always_comb
    begin
        logic [NIBBLE_W-1:0] s;
        high_next = '0;
        low_next  = '0;
        for (int k = 0; k < COLS; k++)
        begin
            s = norm[k] + NIBBLE_W'(carry_in[k]);
            if (s >= NIBBLE_W'(RADIX))
            begin
                s = s - NIBBLE_W'(RADIX);
            end
            if (k < DIGITS)
            begin
                low_next[k*NIBBLE_W +: NIBBLE_W] = s;
            end
            else
            begin
                high_next[(k-DIGITS)*NIBBLE_W +: NIBBLE_W] = s;
            end
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_in)
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (ready_in && ctl_in.valid)
        begin
            bad_reg  <= ctl_in.bad;
            high_reg <= high_next;
            low_reg  <= low_next;
        end
    end

    assign out_valid        = valid_reg;
    assign invalid_digit    = bad_reg;
    assign product_high_bcd = high_reg;
    assign product_low_bcd  = low_reg;

endmodule

[tb/sv/bcd_product_checker.sv]
// checker for the packed-bcd multiplier: watches both channels, predicts each product
// depends on ddm_pkg; instantiated beside the block by the testbench top
`timescale 1ns / 100ps

module bcd_product_checker #(
    parameter int DIGITS = ddm_pkg::DIGITS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [ddm_pkg::WORD_W-1:0] multiplicand_bcd,
    input  logic [ddm_pkg::WORD_W-1:0] multiplier_bcd,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [ddm_pkg::WORD_W-1:0] product_high_bcd,
    input  logic [ddm_pkg::WORD_W-1:0] product_low_bcd,
    input  logic                       invalid_digit,
    output int                         fail_count,
    output int                         pending
);
    import ddm_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] high;
        logic [WORD_W-1:0] low;
        logic              invalid;
    } product_word_t;

    product_word_t expected_products[$];
    product_word_t oldest;

    // exact decimal product of two packed-bcd operands, zero on a bad nibble
    function automatic product_word_t bcd_product(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        product_word_t     res;
        logic [63:0]       val_a;
        logic [63:0]       val_b;
        logic [63:0]       prod;
        logic [NIBBLE_W-1:0] nib_a;
        logic [NIBBLE_W-1:0] nib_b;
        logic              bad;
        res   = '0;
        val_a = '0;
        val_b = '0;
        bad   = 1'b0;
        // digits above DIGITS-1 are ignored
        for (int i = DIGITS - 1; i >= 0; i--)
        begin
            nib_a = a[NIBBLE_W*i +: NIBBLE_W];
            nib_b = b[NIBBLE_W*i +: NIBBLE_W];
            if (nib_a > DIGIT_MAX || nib_b > DIGIT_MAX)
                bad = 1'b1;
            val_a = val_a * RADIX + nib_a;
            val_b = val_b * RADIX + nib_b;
        end
        if (bad)
        begin
            res.invalid = 1'b1;
            return res;
        end
        prod = val_a * val_b;
        // low half first, then high half
        for (int i = 0; i < DIGITS; i++)
        begin
            res.low[NIBBLE_W*i +: NIBBLE_W] = NIBBLE_W'(prod % RADIX);
            prod = prod / RADIX;
        end
        for (int i = 0; i < DIGITS; i++)
        begin
            res.high[NIBBLE_W*i +: NIBBLE_W] = NIBBLE_W'(prod % RADIX);
            prod = prod / RADIX;
        end
        return res;
    endfunction

    // compare each output word with the oldest prediction, then queue new input words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_products.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_products.size() == 0)
                begin
                    $error("output word with no prediction waiting: high %h low %h invalid %b",
                           product_high_bcd, product_low_bcd, invalid_digit);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_products.pop_front();
                    if (product_high_bcd !== oldest.high)
                    begin
                        $error("product_high_bcd: expected %h, got %h",
                               oldest.high, product_high_bcd);
                        fail_count++;
                    end
                    if (product_low_bcd !== oldest.low)
                    begin
                        $error("product_low_bcd: expected %h, got %h",
                               oldest.low, product_low_bcd);
                        fail_count++;
                    end
                    if (invalid_digit !== oldest.invalid)
                    begin
                        $error("invalid_digit: expected %b, got %b",
                               oldest.invalid, invalid_digit);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_products.insert(expected_products.size(),
                                         bcd_product(multiplicand_bcd, multiplier_bcd));
            pending = expected_products.size();
        end
    end

endmodule

[tb/sv/testbench.sv]
// top of the packed-bcd multiplier testbench: clock, reset, stimulus and verdict
// depends on ddm_pkg, decimal_digit_multiplier and bcd_product_checker
`timescale 1ns / 100ps

module testbench;
    import ddm_pkg::*;

    localparam int HOLD_CYCLES   = 80;
    localparam int RANDOM_WORDS  = 1500;
    localparam int PHASE_WORDS   = RANDOM_WORDS / 8;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [WORD_W-1:0] multiplicand_bcd;
    logic [WORD_W-1:0] multiplier_bcd;
    logic              out_valid;
    logic              out_stall;
    logic [WORD_W-1:0] product_high_bcd;
    logic [WORD_W-1:0] product_low_bcd;
    logic              invalid_digit;
    int                fail_count;
    int                pending;

    int idle_pct  = 0;
    int stall_pct = 0;
    bit long_hold = 1'b0;

    decimal_digit_multiplier DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .multiplicand_bcd (multiplicand_bcd),
        .multiplier_bcd   (multiplier_bcd),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .product_high_bcd (product_high_bcd),
        .product_low_bcd  (product_low_bcd),
        .invalid_digit    (invalid_digit)
    );

    bcd_product_checker product_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .multiplicand_bcd (multiplicand_bcd),
        .multiplier_bcd   (multiplier_bcd),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .product_high_bcd (product_high_bcd),
        .product_low_bcd  (product_low_bcd),
        .invalid_digit    (invalid_digit),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // offer one word, with random idle cycles ahead of it, and wait until taken
    task automatic send_word(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid         <= 1'b1;
        multiplicand_bcd <= a;
        multiplier_bcd   <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop offering words until every predicted product has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // random operand: mostly legal digits in a few shapes, sometimes a bad nibble
    function automatic logic [WORD_W-1:0] random_operand(input int bad_pct);
        logic [WORD_W-1:0] w;
        int                shape;
        int                used;
        int                pos;
        w     = '0;
        shape = $urandom_range(9);
        used  = $urandom_range(MAX_DIGITS, 1);
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            case (shape)
                0: w[NIBBLE_W*i +: NIBBLE_W] = NIBBLE_W'(DIGIT_MAX);
                1: w[NIBBLE_W*i +: NIBBLE_W] = (i < used) ? NIBBLE_W'($urandom_range(DIGIT_MAX))
                                                          : '0;
                2: w[NIBBLE_W*i +: NIBBLE_W] = ($urandom_range(3) == 0)
                                               ? NIBBLE_W'($urandom_range(DIGIT_MAX)) : '0;
                default: w[NIBBLE_W*i +: NIBBLE_W] = NIBBLE_W'($urandom_range(DIGIT_MAX));
            endcase
        end
        if ($urandom_range(99) < bad_pct)
        begin
            pos = $urandom_range(MAX_DIGITS - 1);
            w[NIBBLE_W*pos +: NIBBLE_W] = NIBBLE_W'($urandom_range(15, DIGIT_MAX + 1));
        end
        return w;
    endfunction

    // stimulus and verdict
    initial
    begin
        in_valid         <= 1'b0;
        multiplicand_bcd <= '0;
        multiplier_bcd   <= '0;
        rst_n            <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words: extremes, bad nibbles, carry chains
        send_word(32'h0000_0000, 32'h0000_0000);
        send_word(32'h9999_9999, 32'h9999_9999);
        send_word(32'h0000_0001, 32'h0000_0001);
        send_word(32'h0000_0000, 32'h9999_9999);
        send_word(32'h9999_9999, 32'h0000_0001);
        send_word(32'h1000_0000, 32'h1000_0000);
        send_word(32'h1234_5678, 32'h8765_4321);
        send_word(32'h5000_0000, 32'h0000_0002);
        send_word(32'h9999_9999, 32'h0000_0002);
        send_word(32'hA000_0000, 32'h0000_0001);
        send_word(32'h0000_0001, 32'h0000_000F);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'h0000_0000, 32'h0B00_0000);
        send_word(32'h9999_999A, 32'h9999_9999);
        send_word(32'h5555_5555, 32'h2222_2222);
        send_word(32'h0999_0000, 32'h0000_0999);

        // random words over the idle and stall phases, twice round
        for (int round = 0; round < 2; round++)
        begin
            for (int phase = 0; phase < 4; phase++)
            begin
                case (phase)
                    0: begin idle_pct = 0;  stall_pct = 0;  end
                    1: begin idle_pct = 46; stall_pct = 0;  end
                    2: begin idle_pct = 0;  stall_pct = 46; end
                    default: begin idle_pct = 22; stall_pct = 22; end
                endcase
                repeat (PHASE_WORDS) send_word(random_operand(10), random_operand(10));

                // back pressure: long receiver hold while words keep coming
                if (round == 0 && phase == 1)
                begin
                    idle_pct  = 0;
                    long_hold = 1'b1;
                    repeat (30) send_word(random_operand(10), random_operand(10));
                    idle_pct = 46;
                end

                // sender pause until the pipeline is empty
                if (round == 1 && phase == 2)
                    wait_drained();
            end
        end

        // drain, then a quiet spell before the verdict
        wait_drained();
        repeat (10) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
